>>> src/cmpd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package cmpd_pkg;
    localparam int COORD_W = 24;
    localparam int DIFF_W = COORD_W + 3;
    localparam int SQ_W = 2 * DIFF_W;
    localparam int ACC_W = SQ_W + 2;
    localparam int DIST_W = (ACC_W + 1) / 2;
    localparam int SUM_W = 40;
    localparam int MEAN_W = 27;
    localparam int CNT_W = 13;
    localparam int MAX_POINTS = 4096;
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    typedef struct packed {
        logic [DIFF_W-1:0] dx;
        logic [DIFF_W-1:0] dy;
        logic [DIFF_W-1:0] dz;
        logic              first;
        logic              last;
    } job_t;
endpackage
`default_nettype wire

>>> src/cmpd_front.sv
`timescale 1ns / 1ps
`default_nettype none
module cmpd_front import cmpd_pkg::*; (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic [6*COORD_W-1:0]      in_coords,
    input  wire logic                      in_last,
    output logic                           job_valid,
    input  wire logic                      job_ready,
    output job_t                           job
);
    logic signed [COORD_W-1:0] org_reg [6];
    logic first_reg;
    logic [QPTR_W:0] wr_reg, rd_reg;
    job_t q_reg [QDEPTH];
    logic signed [COORD_W-1:0] p [6];
    logic signed [DIFF_W-1:0] t [6];
    job_t nj;
    logic full, take;

    always_comb begin
        for (int i = 0; i < 6; i++) begin
            p[i] = in_coords[i*COORD_W +: COORD_W];
            t[i] = first_reg ? '0 : DIFF_W'(p[i]) - DIFF_W'(org_reg[i]);
        end
        nj.dx = t[0] - t[3];
        nj.dy = t[1] - t[4];
        nj.dz = t[2] - t[5];
        nj.first = first_reg;
        nj.last = in_last;
    end

    assign full = (wr_reg[QPTR_W] != rd_reg[QPTR_W]) &&
                  (wr_reg[QPTR_W-1:0] == rd_reg[QPTR_W-1:0]);
    // hold ready low while in reset
    assign in_ready = aresetn && !full;
    assign take = in_valid && in_ready;
    assign job_valid = wr_reg != rd_reg;
    assign job = q_reg[rd_reg[QPTR_W-1:0]];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_reg <= 1'b1;
            wr_reg <= '0;
            rd_reg <= '0;
        end else begin
            if (take) begin
                first_reg <= in_last;
                wr_reg <= wr_reg + 1'b1;
                if (first_reg) begin
                    for (int i = 0; i < 6; i++) org_reg[i] <= p[i];
                end
            end
            if (job_valid && job_ready) rd_reg <= rd_reg + 1'b1;
        end
        if (take) q_reg[wr_reg[QPTR_W-1:0]] <= nj;
    end
endmodule
`default_nettype wire

>>> src/cmpd_back.sv
`timescale 1ns / 1ps
`default_nettype none
module cmpd_back import cmpd_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              job_valid,
    output logic                   job_ready,
    input  wire job_t              job,
    output logic                   res_valid,
    input  wire logic              res_ready,
    output logic [MEAN_W-1:0]      res_mean,
    output logic [CNT_W-1:0]       res_count
);
    typedef enum logic [2:0] {S_IDLE, S_SQ, S_ROOT, S_ACC, S_DIV, S_OUT} state_t;
    state_t state_reg;
    logic [DIFF_W-1:0] mag_reg [3];
    logic [1:0] k_reg;
    logic [ACC_W-1:0] n_reg, r_reg;
    logic [5:0] step_reg;
    logic [SUM_W-1:0] sum_reg, quo_reg, rem_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic last_reg;
    logic [SQ_W-1:0] sq;
    logic [ACC_W-1:0] bitv, trial;
    logic [SUM_W:0] sadd;
    logic [SUM_W:0] rsh;

    assign job_ready = state_reg == S_IDLE;
    assign res_valid = state_reg == S_OUT;
    assign res_mean = (quo_reg > SUM_W'((1 << MEAN_W) - 1)) ? '1 : quo_reg[MEAN_W-1:0];
    assign sq = mag_reg[k_reg] * mag_reg[k_reg];
    assign bitv = ACC_W'(1) << {step_reg[4:0], 1'b0};
    assign trial = r_reg + bitv;
    assign sadd = {1'b0, sum_reg} + (SUM_W+1)'(r_reg);
    assign rsh = {rem_reg, quo_reg[SUM_W-1]};

    // per pair: squares, bit-serial root, accumulate; counts are tiny: restoring divide, one quotient bit per cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            sum_reg <= '0;
            cnt_reg <= '0;
        end else begin
            case (state_reg)
                S_IDLE: if (job_valid) begin
                    mag_reg[0] <= job.dx[DIFF_W-1] ? -job.dx : job.dx;
                    mag_reg[1] <= job.dy[DIFF_W-1] ? -job.dy : job.dy;
                    mag_reg[2] <= job.dz[DIFF_W-1] ? -job.dz : job.dz;
                    if (job.first) begin
                        sum_reg <= '0;
                        cnt_reg <= '0;
                    end
                    last_reg <= job.last;
                    k_reg <= '0;
                    n_reg <= '0;
                    state_reg <= S_SQ;
                end
                S_SQ: begin
                    n_reg <= n_reg + ACC_W'(sq);
                    k_reg <= k_reg + 1'b1;
                    if (k_reg == 2'd2) begin
                        state_reg <= S_ROOT;
                        r_reg <= '0;
                        step_reg <= 6'(DIST_W - 1);
                    end
                end
                S_ROOT: begin
                    if (n_reg >= trial) begin
                        n_reg <= n_reg - trial;
                        r_reg <= (r_reg >> 1) + bitv;
                    end else begin
                        r_reg <= r_reg >> 1;
                    end
                    if (step_reg == '0) state_reg <= S_ACC;
                    else step_reg <= step_reg - 1'b1;
                end
                S_ACC: begin
                    sum_reg <= sadd[SUM_W] ? '1 : sadd[SUM_W-1:0];
                    if (cnt_reg < CNT_W'(MAX_POINTS)) cnt_reg <= cnt_reg + 1'b1;
                    if (last_reg) begin
                        quo_reg <= sadd[SUM_W] ? '1 : sadd[SUM_W-1:0];
                        rem_reg <= '0;
                        step_reg <= 6'(SUM_W - 1);
                        state_reg <= S_DIV;
                    end else begin
                        state_reg <= S_IDLE;
                    end
                end
                S_DIV: begin
                    if (rsh >= (SUM_W+1)'(cnt_reg)) begin
                        rem_reg <= SUM_W'(rsh - (SUM_W+1)'(cnt_reg));
                        quo_reg <= {quo_reg[SUM_W-2:0], 1'b1};
                    end else begin
                        rem_reg <= rsh[SUM_W-1:0];
                        quo_reg <= {quo_reg[SUM_W-2:0], 1'b0};
                    end
                    if (step_reg == '0) state_reg <= S_OUT;
                    else step_reg <= step_reg - 1'b1;
                end
                S_OUT: if (res_ready) begin
                    state_reg <= S_IDLE;
                    sum_reg <= '0;
                    cnt_reg <= '0;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
    assign res_count = cnt_reg;
endmodule
`default_nettype wire

>>> src/curve_mean_point_distance_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Mean distance between two aligned 3D curves. The front end takes one point
// pair per cycle while its queue has room, subtracts the latched origins and
// queues the differences in a four-entry queue; the back end takes one pair at a
// time, squares the three components one after another, runs a bit-serial
// square root and accumulates the result before it takes the next pair. A last
// pair adds a restoring divide before the result is presented.
module curve_mean_point_distance_unit import cmpd_pkg::*; (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // a_x, a_y, a_z, b_x, b_y, b_z (24 bits each, lowest first)
    input  wire logic [143:0] s_tdata,
    input  wire logic         s_tlast,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // mean_distance[26:0], point_count[39:27], zero pad
    output logic [47:0]       m_tdata
);
    logic job_valid, job_ready;
    job_t job;
    logic [MEAN_W-1:0] mean;
    logic [CNT_W-1:0] cnt;

    cmpd_front u_front (
        .aclk, .aresetn, .in_valid(s_tvalid), .in_ready(s_tready),
        .in_coords(s_tdata), .in_last(s_tlast),
        .job_valid, .job_ready, .job
    );
    cmpd_back u_back (
        .aclk, .aresetn, .job_valid, .job_ready, .job,
        .res_valid(m_tvalid), .res_ready(m_tready), .res_mean(mean), .res_count(cnt)
    );
    assign m_tdata = {8'd0, cnt, mean};

    a_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (cnt != '0))
        else $error("zero count on result");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");
endmodule
`default_nettype wire

>>> tb/tb_curve_mean_point_distance_unit.sv
`timescale 1ns / 1ps
module tb_curve_mean_point_distance_unit;
    import cmpd_pkg::*;

    typedef struct {
        logic [143:0] data;
        logic         last;
    } pair_item_t;

    typedef struct {
        logic [MEAN_W-1:0] mean;
        logic [CNT_W-1:0]  count;
    } mean_result_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [143:0] s_tdata;
    logic         s_tlast;
    logic         m_tvalid;
    logic         m_tready;
    logic [47:0]  m_tdata;

    curve_mean_point_distance_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    pair_item_t   pending_pairs[$];
    mean_result_t expected_means[$];
    int           errors;
    int           send_idle_pct;
    int           recv_idle_pct;
    int           quiet_cycles;
    bit           in_took;

    // predictor state
    longint             org[6];
    logic [SUM_W-1:0]   run_sum;
    int                 run_pairs;
    bit                 run_fresh;

    function automatic longint coord(logic [143:0] d, int i);
        logic signed [23:0] c;
        c = d[i*24 +: 24];
        return longint'(c);
    endfunction

    function automatic longint floor_sqrt(longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return longint'(r);
    endfunction

    task automatic predict_pair(pair_item_t it);
        longint p[6];
        longint unsigned sq;
        longint d;
        longint unsigned s;
        longint unsigned mean;
        mean_result_t r;
        for (int i = 0; i < 6; i++) p[i] = coord(it.data, i);
        if (run_fresh) begin
            for (int i = 0; i < 6; i++) org[i] = p[i];
            run_sum = 0;
            run_pairs = 0;
            run_fresh = 0;
        end
        sq = 0;
        for (int i = 0; i < 3; i++) begin
            d = (p[i] - org[i]) - (p[i+3] - org[i+3]);
            sq += longint'(d * d);
        end
        s = longint'(run_sum) + floor_sqrt(sq);
        if (s > 64'hFF_FFFF_FFFF) s = 64'hFF_FFFF_FFFF;
        run_sum = s[SUM_W-1:0];
        if (run_pairs < MAX_POINTS) run_pairs++;
        if (it.last) begin
            mean = longint'(run_sum) / run_pairs;
            if (mean > (64'd1 << MEAN_W) - 1) mean = (64'd1 << MEAN_W) - 1;
            r.mean = mean[MEAN_W-1:0];
            r.count = run_pairs[CNT_W-1:0];
            expected_means.insert(expected_means.size(), r);
            run_fresh = 1;
        end
    endtask

    function automatic logic [23:0] rand_coord(int mode);
        case (mode)
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2: return 24'($urandom_range(0, 255)) - 24'd128;
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic add_pair(logic [143:0] d, logic l);
        pair_item_t it;
        it.data = d;
        it.last = l;
        pending_pairs.insert(pending_pairs.size(), it);
    endtask

    task automatic add_run(int len, int mode);
        logic [143:0] d;
        for (int k = 0; k < len; k++) begin
            for (int i = 0; i < 6; i++)
                d[i*24 +: 24] = rand_coord(mode == 3 ? $urandom_range(0, 3) : mode);
            add_pair(d, k == len - 1);
        end
    endtask

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    // driver
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 0;
        end else begin
            if (!s_tvalid || in_took) begin
                if (pending_pairs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    s_tvalid <= 1;
                    s_tdata <= pending_pairs[0].data;
                    s_tlast <= pending_pairs[0].last;
                end else begin
                    s_tvalid <= 0;
                end
            end
        end
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // monitor
    always @(posedge aclk) begin
        in_took <= aresetn && s_tvalid && s_tready;
        if (aresetn) begin
            if (s_tvalid && s_tready) predict_pair(pending_pairs.pop_front());
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
            if (m_tvalid && m_tready) begin
                if (expected_means.size() == 0) begin
                    $display("%0t unexpected result: actual mean %0d count %0d",
                             $time, m_tdata[26:0], m_tdata[39:27]);
                    errors++;
                end else begin
                    if (m_tdata[26:0] !== expected_means[0].mean) begin
                        $display("%0t mean mismatch: expected %0d actual %0d",
                                 $time, expected_means[0].mean, m_tdata[26:0]);
                        errors++;
                    end
                    if (m_tdata[39:27] !== expected_means[0].count) begin
                        $display("%0t count mismatch: expected %0d actual %0d",
                                 $time, expected_means[0].count, m_tdata[39:27]);
                        errors++;
                    end
                    void'(expected_means.pop_front());
                end
            end
        end
    end

    // watchdog
    initial begin
        wait (aresetn);
        forever begin
            @(posedge aclk);
            if (quiet_cycles >= 20000) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    initial begin
        logic [143:0] d;
        errors = 0;
        quiet_cycles = 0;
        run_fresh = 1;
        run_sum = 0;
        run_pairs = 0;
        send_idle_pct = 25;
        recv_idle_pct = 81;
        aresetn = 0;
        s_tvalid = 0;
        s_tdata = '0;
        s_tlast = 0;
        m_tready = 0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;

        // single-pair runs, extremes, mixed extremes, short runs
        add_run(1, 2);
        add_run(1, 0);
        add_pair('0, 0);
        add_pair({6{24'h7FFFFF}}, 1);
        d = '0;
        for (int i = 0; i < 3; i++) d[i*24 +: 24] = 24'h800000;
        add_pair('0, 0);
        add_pair(d, 0);
        d = '0;
        for (int i = 3; i < 6; i++) d[i*24 +: 24] = 24'h800000;
        add_pair(d, 1);
        add_pair({{3{24'h7FFFFF}}, {3{24'h800000}}}, 0);
        add_pair({{3{24'h800000}}, {3{24'h7FFFFF}}}, 1);
        add_run(6, 1);
        add_run(5, 3);

        for (int phase = 0; phase < 3; phase++) begin
            int sent;
            sent = 0;
            while (sent < 305) begin
                int len;
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 8);
                add_run(len, $urandom_range(0, 9) < 7 ? 3 : $urandom_range(0, 2));
                sent += len;
            end
            wait (pending_pairs.size() == 0 && expected_means.size() == 0);
            if (phase == 0) begin
                send_idle_pct = 81;
                recv_idle_pct = 25;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
        end
        repeat (100) @(posedge aclk);
        if (errors == 0 && expected_means.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

>>> curve_mean_point_distance_unit.f
src/cmpd_pkg.sv
src/cmpd_front.sv
src/cmpd_back.sv
src/curve_mean_point_distance_unit.sv
tb/tb_curve_mean_point_distance_unit.sv
